>>> hw/rtl/avp_pkg.sv
`default_nettype none

package avp_pkg;

    // field widths
    localparam int POS_W   = 16;
    localparam int ERR_W   = 17;
    localparam int TGT_W   = 15;
    localparam int FIELD_W = 16;
    localparam int PROD_W  = 2 * FIELD_W;
    localparam int GAIN_W  = PROD_W - 8;

    // configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TARGET_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FORWARD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCES  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FLOORS      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CEILINGS    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_GAIN  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_YAW_GAIN    = 3'd7;

    // reset values
    localparam logic [TGT_W-1:0]   RST_TARGET_X    = 15'd500;
    localparam logic [15:0]        RST_TARGET_Y    = 16'd0;
    localparam logic [TGT_W-1:0]   RST_MIN_FORWARD = 15'd0;
    localparam logic [47:0]        RST_TOLERANCES  = {16'd50, 16'd20, 16'd20};
    localparam logic [31:0]        RST_FLOORS      = {16'd100, 16'd100};
    localparam logic [47:0]        RST_CEILINGS    = {16'd1000, 16'd300, 16'd500};
    localparam logic [FIELD_W-1:0] RST_SPEED_GAIN  = 16'd256;
    localparam logic [FIELD_W-1:0] RST_YAW_GAIN    = 16'd256;

    typedef enum logic [1:0] {
        ST_INVALID  = 2'd0,
        ST_OVERSHOT = 2'd1,
        ST_ARRIVED  = 2'd2,
        ST_CLOSING  = 2'd3
    } approach_state_t;

    // floor first, then ceiling
    function automatic logic [FIELD_W-1:0] clamp_speed(
        input logic [GAIN_W-1:0]  v,
        input logic [FIELD_W-1:0] lo,
        input logic [FIELD_W-1:0] hi
    );
        logic [GAIN_W-1:0] t;
        t = (v < GAIN_W'(lo)) ? GAIN_W'(lo) : v;
        if (t > GAIN_W'(hi))
        begin
            t = GAIN_W'(hi);
        end
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [ERR_W-1:0] apply_sign(
        input logic               neg,
        input logic [FIELD_W-1:0] mag
    );
        logic [ERR_W-1:0] m;
        m = {1'b0, mag};
        return neg ? (ERR_W'(0) - m) : m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/avp_if.sv
`default_nettype none

interface avp_pose_if;
    logic        valid;
    logic        ready;
    logic [15:0] object_x_mm;
    logic [15:0] object_y_mm;
    logic [15:0] heading_error_mrad;

    modport source (output valid, object_x_mm, object_y_mm, heading_error_mrad, input ready);
    modport sink   (input valid, object_x_mm, object_y_mm, heading_error_mrad, output ready);
endinterface

interface avp_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  approach_state;
    logic [16:0] forward_error_mm;
    logic [16:0] lateral_error_mm;
    logic [16:0] forward_speed;
    logic [16:0] lateral_speed;
    logic [16:0] yaw_rate;

    modport source (output valid, approach_state, forward_error_mm, lateral_error_mm,
                    forward_speed, lateral_speed, yaw_rate, input ready);
    modport sink   (input valid, approach_state, forward_error_mm, lateral_error_mm,
                    forward_speed, lateral_speed, yaw_rate, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/approach_velocity_planner_top.sv
// order: input register, one pass of logic, result register; an accepted pose moves on to
//   the result register when that stage advances, and its command is offered from there
// throughput: one transaction per cycle while cmd.ready is high
// stalls: pose.ready drops only while both registers are full and cmd.ready is low
// reset (rst_n low, asynchronous): both registers emptied, settings return to their defaults
`default_nettype none

module approach_velocity_planner_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [avp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [avp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [avp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // channels
    avp_pose_if.sink                             pose,
    avp_cmd_if.source                            cmd
);

    // ------------------------------------------------------------------
    // settings registers
    // ------------------------------------------------------------------
    logic [avp_pkg::TGT_W-1:0]   target_x_reg;
    logic [15:0]                 target_y_reg;
    logic [avp_pkg::TGT_W-1:0]   min_forward_reg;
    logic [47:0]                 tolerances_reg;
    logic [31:0]                 floors_reg;
    logic [47:0]                 ceilings_reg;
    logic [avp_pkg::FIELD_W-1:0] speed_gain_reg;
    logic [avp_pkg::FIELD_W-1:0] yaw_gain_reg;

    logic                          cfg_write;
    logic [avp_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // registers sit at 8-byte strides, low address bits ignored
    assign cfg_idx   = paddr[avp_pkg::APB_ADDR_W-1:avp_pkg::APB_ADDR_W-avp_pkg::REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg    <= avp_pkg::RST_TARGET_X;
            target_y_reg    <= avp_pkg::RST_TARGET_Y;
            min_forward_reg <= avp_pkg::RST_MIN_FORWARD;
            tolerances_reg  <= avp_pkg::RST_TOLERANCES;
            floors_reg      <= avp_pkg::RST_FLOORS;
            ceilings_reg    <= avp_pkg::RST_CEILINGS;
            speed_gain_reg  <= avp_pkg::RST_SPEED_GAIN;
            yaw_gain_reg    <= avp_pkg::RST_YAW_GAIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                avp_pkg::REG_TARGET_X:    target_x_reg    <= pwdata[avp_pkg::TGT_W-1:0];
                avp_pkg::REG_TARGET_Y:    target_y_reg    <= pwdata[15:0];
                avp_pkg::REG_MIN_FORWARD: min_forward_reg <= pwdata[avp_pkg::TGT_W-1:0];
                avp_pkg::REG_TOLERANCES:  tolerances_reg  <= pwdata[47:0];
                avp_pkg::REG_FLOORS:      floors_reg      <= pwdata[31:0];
                avp_pkg::REG_CEILINGS:    ceilings_reg    <= pwdata[47:0];
                avp_pkg::REG_SPEED_GAIN:  speed_gain_reg  <= pwdata[15:0];
                avp_pkg::REG_YAW_GAIN:    yaw_gain_reg    <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (cfg_idx)
            avp_pkg::REG_TARGET_X:    prdata = avp_pkg::APB_DATA_W'(target_x_reg);
            avp_pkg::REG_TARGET_Y:    prdata = avp_pkg::APB_DATA_W'(target_y_reg);
            avp_pkg::REG_MIN_FORWARD: prdata = avp_pkg::APB_DATA_W'(min_forward_reg);
            avp_pkg::REG_TOLERANCES:  prdata = avp_pkg::APB_DATA_W'(tolerances_reg);
            avp_pkg::REG_FLOORS:      prdata = avp_pkg::APB_DATA_W'(floors_reg);
            avp_pkg::REG_CEILINGS:    prdata = avp_pkg::APB_DATA_W'(ceilings_reg);
            avp_pkg::REG_SPEED_GAIN:  prdata = avp_pkg::APB_DATA_W'(speed_gain_reg);
            avp_pkg::REG_YAW_GAIN:    prdata = avp_pkg::APB_DATA_W'(yaw_gain_reg);
            default:                  prdata = '0;
        endcase
    end

    // unpacked views of the packed settings
    logic [15:0] tol_x, tol_y, tol_h;
    logic [15:0] floor_x, floor_y;
    logic [15:0] ceil_x, ceil_y, ceil_yaw;

    assign tol_x    = tolerances_reg[15:0];
    assign tol_y    = tolerances_reg[31:16];
    assign tol_h    = tolerances_reg[47:32];
    assign floor_x  = floors_reg[15:0];
    assign floor_y  = floors_reg[31:16];
    assign ceil_x   = ceilings_reg[15:0];
    assign ceil_y   = ceilings_reg[31:16];
    assign ceil_yaw = ceilings_reg[47:32];

    // ------------------------------------------------------------------
    // flow control: stage 0 input register, stage 1 result register
    // a stage loads when it is empty or its content moves on this cycle
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg;
    logic adv0, adv1;

    assign adv1       = !v1_reg || cmd.ready;
    assign adv0       = !v0_reg || adv1;
    assign pose.ready = adv0;
    assign cmd.valid  = v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= pose.valid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: captured pose
    // ------------------------------------------------------------------
    logic [15:0] x0_reg, y0_reg, h0_reg;

    always_ff @(posedge clk)
    begin
        if (adv0 && pose.valid)
        begin
            x0_reg <= pose.object_x_mm;
            y0_reg <= pose.object_y_mm;
            h0_reg <= pose.heading_error_mrad;
        end
    end

    // errors, magnitudes, the three gain products, settings check and overshoot test
    logic [avp_pkg::ERR_W-1:0]   err_x, err_y, hx17;
    logic [avp_pkg::ERR_W-1:0]   magx17, magy17, magh17;
    logic [avp_pkg::FIELD_W-1:0] magx, magy, magh;
    logic [avp_pkg::PROD_W-1:0]  prod_x, prod_y, prod_h;
    logic [avp_pkg::ERR_W-1:0]   window;
    logic                        usable, over;

    assign err_x = {x0_reg[15], x0_reg} - {2'b00, target_x_reg};
    assign err_y = {y0_reg[15], y0_reg} - {target_y_reg[15], target_y_reg};
    assign hx17  = {h0_reg[15], h0_reg};

    assign magx17 = err_x[avp_pkg::ERR_W-1] ? (avp_pkg::ERR_W'(0) - err_x) : err_x;
    assign magy17 = err_y[avp_pkg::ERR_W-1] ? (avp_pkg::ERR_W'(0) - err_y) : err_y;
    assign magh17 = hx17[avp_pkg::ERR_W-1]  ? (avp_pkg::ERR_W'(0) - hx17)  : hx17;
    // every magnitude is at most 65535
    assign magx   = magx17[avp_pkg::FIELD_W-1:0];
    assign magy   = magy17[avp_pkg::FIELD_W-1:0];
    assign magh   = magh17[avp_pkg::FIELD_W-1:0];

    assign prod_x = magx * speed_gain_reg;
    assign prod_y = magy * speed_gain_reg;
    assign prod_h = magh * yaw_gain_reg;

    // approach window: target minus forward tolerance, signed
    assign window = {2'b00, target_x_reg} - {1'b0, tol_x};

    assign usable = (target_x_reg != '0) && (tol_x != '0) && (tol_y != '0) &&
                    (tol_h != '0) &&
                    ($signed({2'b00, min_forward_reg}) < $signed(window)) &&
                    (floor_x != '0) && (floor_y != '0) &&
                    (floor_x <= ceil_x) && (floor_y <= ceil_y) &&
                    (ceil_yaw != '0) && (speed_gain_reg != '0) && (yaw_gain_reg != '0);

    assign over = $signed({x0_reg[15], x0_reg}) < $signed({2'b00, min_forward_reg});

    // clamp, sign and state decision
    logic [avp_pkg::FIELD_W-1:0] sx, sy, sw;
    logic [avp_pkg::ERR_W-1:0]   vx, vy, yaw;
    avp_pkg::approach_state_t    state_next;
    logic [avp_pkg::ERR_W-1:0]   fe_next, le_next, fs_next, ls_next, yaw_next;

    // gained value is the product shifted right by 8
    assign sx  = avp_pkg::clamp_speed(prod_x[avp_pkg::PROD_W-1:8], floor_x, ceil_x);
    assign sy  = avp_pkg::clamp_speed(prod_y[avp_pkg::PROD_W-1:8], floor_y, ceil_y);
    // yaw has no floor
    assign sw  = avp_pkg::clamp_speed(prod_h[avp_pkg::PROD_W-1:8], '0, ceil_yaw);
    assign vx  = (magx > tol_x) ? avp_pkg::apply_sign(err_x[avp_pkg::ERR_W-1], sx) : '0;
    assign vy  = (magy > tol_y) ? avp_pkg::apply_sign(err_y[avp_pkg::ERR_W-1], sy) : '0;
    assign yaw = (magh > tol_h) ? avp_pkg::apply_sign(h0_reg[15], sw) : '0;

    always_comb
    begin
        state_next = avp_pkg::ST_INVALID;
        fe_next    = '0;
        le_next    = '0;
        fs_next    = '0;
        ls_next    = '0;
        yaw_next   = '0;
        if (usable)
        begin
            fe_next = err_x;
            le_next = err_y;
            if (over)
            begin
                state_next = avp_pkg::ST_OVERSHOT;
            end
            else if ((vx == '0) && (vy == '0))
            begin
                state_next = avp_pkg::ST_ARRIVED;
            end
            else
            begin
                state_next = avp_pkg::ST_CLOSING;
                fs_next    = vx;
                ls_next    = vy;
                yaw_next   = yaw;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: result register
    // ------------------------------------------------------------------
    avp_pkg::approach_state_t  state_reg;
    logic [avp_pkg::ERR_W-1:0] fe_reg, le_reg, fs_reg, ls_reg, yaw_reg;

    always_ff @(posedge clk)
    begin
        if (adv1 && v0_reg)
        begin
            state_reg <= state_next;
            fe_reg    <= fe_next;
            le_reg    <= le_next;
            fs_reg    <= fs_next;
            ls_reg    <= ls_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign cmd.approach_state   = state_reg;
    assign cmd.forward_error_mm = fe_reg;
    assign cmd.lateral_error_mm = le_reg;
    assign cmd.forward_speed    = fs_reg;
    assign cmd.lateral_speed    = ls_reg;
    assign cmd.yaw_rate         = yaw_reg;

`ifndef SYNTHESIS
    // invalid settings zero every field
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.approach_state == avp_pkg::ST_INVALID)) |->
        (cmd.forward_error_mm == '0 && cmd.lateral_error_mm == '0 &&
         cmd.forward_speed == '0 && cmd.lateral_speed == '0 && cmd.yaw_rate == '0))
        else $error("invalid result carries nonzero fields");

    // only a closing result moves the robot
    a_still_unless_closing: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.approach_state != avp_pkg::ST_CLOSING)) |->
        (cmd.forward_speed == '0 && cmd.lateral_speed == '0 && cmd.yaw_rate == '0))
        else $error("motion commanded outside closing");

    // closing always has some translation speed
    a_closing_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.approach_state == avp_pkg::ST_CLOSING)) |->
        (cmd.forward_speed != '0 || cmd.lateral_speed != '0))
        else $error("closing with both speeds zero");

    // an empty input stage always takes a new pose
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v0_reg |-> pose.ready)
        else $error("input stage empty but not ready");

    // a result that is not taken stays in the output stage
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !cmd.ready) |=> (v1_reg && $stable(fs_reg) && $stable(state_reg)))
        else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

>>> tb/sv/approach_velocity_planner_top_tb.sv
`timescale 1ns / 1ps

module approach_velocity_planner_top_tb;

    // one command word: index 0 is the state, then errors, speeds and yaw rate
    typedef logic [5:0][avp_pkg::ERR_W-1:0] cmd_word_t;

    // one directed pose, with its command typed in where it is obvious
    typedef struct {
        int                       x;
        int                       y;
        int                       h;
        bit                       bad;
        bit                       typed;
        avp_pkg::approach_state_t st;
        int                       ex;
        int                       ey;
        int                       vx;
        int                       vy;
        int                       yaw;
    } probe_t;

    localparam int PROBE_N = 21;

    logic clk = 1'b0;
    logic rst_n;

    // configuration port
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [avp_pkg::APB_ADDR_W-1:0] paddr;
    logic [avp_pkg::APB_DATA_W-1:0] pwdata;
    logic [avp_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // pose in, command out
    avp_pose_if pose_ch ();
    avp_cmd_if  cmd_ch ();

    // shadow copy of the settings, masked to the register widths
    logic [63:0] regs [0:7];

    // commands predicted for accepted poses, oldest first
    cmd_word_t expected_cmds [$];

    int mismatches = 0;

    // set for a stretch where neither side ever idles
    bit steady = 1'b0;

    string cmd_labels [0:5] = '{"approach_state", "forward_error_mm", "lateral_error_mm",
                                "forward_speed", "lateral_speed", "yaw_rate"};

    // directed poses at the reset settings, the last three with the speed gain at zero
    probe_t probes [0:PROBE_N-1] = '{
        // exactly on target
        '{500, 0, 0, 0, 1, avp_pkg::ST_ARRIVED, 0, 0, 0, 0, 0},
        // both errors right on the tolerance edge stay inside the deadband
        '{520, 20, 0, 0, 1, avp_pkg::ST_ARRIVED, 20, 20, 0, 0, 0},
        // heading ignored when arrived
        '{480, -20, 32767, 0, 1, avp_pkg::ST_ARRIVED, -20, -20, 0, 0, 0},
        // just outside the deadband, lifted to the floor
        '{521, 0, 0, 0, 1, avp_pkg::ST_CLOSING, 21, 0, 100, 0, 0},
        '{479, -21, 0, 0, 1, avp_pkg::ST_CLOSING, -21, -21, -100, -100, 0},
        // between floor and ceiling
        '{700, 0, 0, 0, 1, avp_pkg::ST_CLOSING, 200, 0, 200, 0, 0},
        // heading on the tolerance edge while closing gives no yaw
        '{1000, 0, 50, 0, 1, avp_pkg::ST_CLOSING, 500, 0, 500, 0, 0},
        '{1000, 0, 51, 0, 1, avp_pkg::ST_CLOSING, 500, 0, 500, 0, 51},
        '{1000, 0, -51, 0, 1, avp_pkg::ST_CLOSING, 500, 0, 500, 0, -51},
        // lateral ceiling reached exactly, yaw ceiling reached exactly
        '{500, 300, -1000, 0, 1, avp_pkg::ST_CLOSING, 0, 300, 0, 300, -1000},
        '{500, -2000, 700, 0, 1, avp_pkg::ST_CLOSING, 0, -2000, 0, -300, 700},
        // zero distance is not below a zero minimum
        '{0, 0, 0, 0, 1, avp_pkg::ST_CLOSING, -500, 0, -500, 0, 0},
        // field extremes, every clamp saturated
        '{32767, 32767, 32767, 0, 1, avp_pkg::ST_CLOSING, 32267, 32767, 500, 300, 1000},
        '{32767, -32768, -32768, 0, 1, avp_pkg::ST_CLOSING, 32267, -32768, 500, -300, -1000},
        // nearer than the minimum forward distance
        '{-1, 100, 500, 0, 1, avp_pkg::ST_OVERSHOT, -501, 100, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 1, avp_pkg::ST_OVERSHOT, -33268, -32768, 0, 0, 0},
        // left to the predictor
        '{12345, -6789, 4321, 0, 0, avp_pkg::ST_INVALID, 0, 0, 0, 0, 0},
        '{-300, 32000, -77, 0, 0, avp_pkg::ST_INVALID, 0, 0, 0, 0, 0},
        // unusable settings zero everything
        '{1000, 0, 100, 1, 1, avp_pkg::ST_INVALID, 0, 0, 0, 0, 0},
        '{-32768, 32767, -32768, 1, 1, avp_pkg::ST_INVALID, 0, 0, 0, 0, 0},
        '{500, 0, 0, 1, 1, avp_pkg::ST_INVALID, 0, 0, 0, 0, 0}
    };

    approach_velocity_planner_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pose    (pose_ch),
        .cmd     (cmd_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------

    // one line per mismatch
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] reg_mask(logic [avp_pkg::REG_IDX_W-1:0] idx);
        case (idx) inside
            avp_pkg::REG_TARGET_X, avp_pkg::REG_MIN_FORWARD:
                return 64'h7fff;
            avp_pkg::REG_TARGET_Y, avp_pkg::REG_SPEED_GAIN, avp_pkg::REG_YAW_GAIN:
                return 64'hffff;
            avp_pkg::REG_FLOORS:
                return 64'hffff_ffff;
            default:
                return 64'hffff_ffff_ffff;
        endcase
    endfunction

    // deadband, gain, floor then ceiling, sign of the error restored
    function automatic int axis_speed(int err, int tol, int gain, int flo, int cei);
        int     mag;
        longint s;
        mag = (err < 0) ? -err : err;
        if (mag <= tol)
        begin
            return 0;
        end
        s = (longint'(mag) * gain) >>> 8;
        if (s < flo)
        begin
            s = flo;
        end
        if (s > cei)
        begin
            s = cei;
        end
        return (err < 0) ? -int'(s) : int'(s);
    endfunction

    // the command one pose should produce under the current settings
    function automatic cmd_word_t plan_approach(logic [15:0] px, logic [15:0] py,
                                                logic [15:0] ph);
        cmd_word_t                w;
        avp_pkg::approach_state_t st;
        int                       x, y, h, tx, ty, minf;
        int                       tol_x, tol_y, tol_h, flo_x, flo_y, cei_x, cei_y, cei_yaw;
        int                       sgain, ygain, ex, ey, vx, vy, yaw, hm;
        longint                   g;
        bit                       usable;
        x       = int'($signed(px));
        y       = int'($signed(py));
        h       = int'($signed(ph));
        tx      = int'(regs[avp_pkg::REG_TARGET_X][14:0]);
        ty      = int'($signed(regs[avp_pkg::REG_TARGET_Y][15:0]));
        minf    = int'(regs[avp_pkg::REG_MIN_FORWARD][14:0]);
        tol_x   = int'(regs[avp_pkg::REG_TOLERANCES][15:0]);
        tol_y   = int'(regs[avp_pkg::REG_TOLERANCES][31:16]);
        tol_h   = int'(regs[avp_pkg::REG_TOLERANCES][47:32]);
        flo_x   = int'(regs[avp_pkg::REG_FLOORS][15:0]);
        flo_y   = int'(regs[avp_pkg::REG_FLOORS][31:16]);
        cei_x   = int'(regs[avp_pkg::REG_CEILINGS][15:0]);
        cei_y   = int'(regs[avp_pkg::REG_CEILINGS][31:16]);
        cei_yaw = int'(regs[avp_pkg::REG_CEILINGS][47:32]);
        sgain   = int'(regs[avp_pkg::REG_SPEED_GAIN][15:0]);
        ygain   = int'(regs[avp_pkg::REG_YAW_GAIN][15:0]);

        usable = tx > 0 && tol_x > 0 && tol_y > 0 && tol_h > 0 && minf < tx - tol_x &&
                 flo_x > 0 && flo_y > 0 && flo_x <= cei_x && flo_y <= cei_y &&
                 cei_yaw > 0 && sgain > 0 && ygain > 0;

        st  = avp_pkg::ST_INVALID;
        ex  = 0;
        ey  = 0;
        vx  = 0;
        vy  = 0;
        yaw = 0;
        if (usable)
        begin
            ex = x - tx;
            ey = y - ty;
            if (x < minf)
            begin
                st = avp_pkg::ST_OVERSHOT;
            end
            else
            begin
                vx = axis_speed(ex, tol_x, sgain, flo_x, cei_x);
                vy = axis_speed(ey, tol_y, sgain, flo_y, cei_y);
                if (vx == 0 && vy == 0)
                begin
                    st = avp_pkg::ST_ARRIVED;
                end
                else
                begin
                    // yaw has a ceiling but no floor
                    st = avp_pkg::ST_CLOSING;
                    hm = (h < 0) ? -h : h;
                    if (hm > tol_h)
                    begin
                        g = (longint'(hm) * ygain) >>> 8;
                        if (g > cei_yaw)
                        begin
                            g = cei_yaw;
                        end
                        yaw = (h < 0) ? -int'(g) : int'(g);
                    end
                end
            end
        end
        w[0] = avp_pkg::ERR_W'(st);
        w[1] = avp_pkg::ERR_W'(ex);
        w[2] = avp_pkg::ERR_W'(ey);
        w[3] = avp_pkg::ERR_W'(vx);
        w[4] = avp_pkg::ERR_W'(vy);
        w[5] = avp_pkg::ERR_W'(yaw);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    // read transaction, compared with the shadow copy; the port is deselected before return
    task automatic check_register(logic [avp_pkg::REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= avp_pkg::APB_ADDR_W'({idx, 3'b000});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & reg_mask(idx)) !== regs[idx])
        begin
            report_mismatch("register readback", prdata & reg_mask(idx), regs[idx]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write transaction with junk above the register width, then read it back
    task automatic set_register(logic [avp_pkg::REG_IDX_W-1:0] idx, logic [63:0] val);
        logic [63:0] data;
        data = (val & reg_mask(idx)) | ({$urandom, $urandom} & ~reg_mask(idx));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= avp_pkg::APB_ADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        regs[idx] = data & reg_mask(idx);
        check_register(idx);
    endtask

    // mostly in a useful range, now and then a field extreme
    function automatic logic [15:0] pick_field(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (r == 0)
        begin
            return 16'h0000;
        end
        if (r == 1)
        begin
            return 16'hffff;
        end
        if (r == 2)
        begin
            return 16'h8000;
        end
        if (r == 3)
        begin
            return 16'h7fff;
        end
        return 16'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    // settings for one phase: all zero, all ones, extreme but usable, or random
    task automatic load_settings(int kind);
        if (kind == 0 || kind == 1)
        begin
            for (int i = 0; i < 8; i++)
            begin
                set_register(avp_pkg::REG_IDX_W'(i), (kind == 0) ? 64'h0 : '1);
            end
        end
        else if (kind == 2)
        begin
            set_register(avp_pkg::REG_TARGET_X, 64'h7fff);
            set_register(avp_pkg::REG_TARGET_Y, 64'h8000);
            set_register(avp_pkg::REG_MIN_FORWARD, 64'h0);
            set_register(avp_pkg::REG_TOLERANCES, {16'd0, 16'd1, 16'd1, 16'd1});
            set_register(avp_pkg::REG_FLOORS, {32'd0, 16'd1, 16'd1});
            set_register(avp_pkg::REG_CEILINGS, {16'd0, 16'hffff, 16'hffff, 16'hffff});
            set_register(avp_pkg::REG_SPEED_GAIN, 64'hffff);
            set_register(avp_pkg::REG_YAW_GAIN, 64'hffff);
        end
        else
        begin
            set_register(avp_pkg::REG_TARGET_X, 64'(pick_field(1, 3000)));
            set_register(avp_pkg::REG_TARGET_Y, 64'(pick_field(-1000, 1000)));
            set_register(avp_pkg::REG_MIN_FORWARD, 64'(pick_field(0, 200)));
            set_register(avp_pkg::REG_TOLERANCES, {16'd0, pick_field(1, 100),
                                                   pick_field(1, 100), pick_field(1, 100)});
            set_register(avp_pkg::REG_FLOORS, {32'd0, pick_field(1, 200), pick_field(1, 200)});
            set_register(avp_pkg::REG_CEILINGS, {16'd0, pick_field(1, 3000),
                                                 pick_field(200, 2000), pick_field(200, 2000)});
            set_register(avp_pkg::REG_SPEED_GAIN, 64'(pick_field(1, 1024)));
            set_register(avp_pkg::REG_YAW_GAIN, 64'(pick_field(1, 1024)));
        end
    endtask

    // ------------------------------------------------------------------
    // pose side
    // ------------------------------------------------------------------

    // one pose transaction; the command it should cause is queued on acceptance
    task automatic send_pose(logic [15:0] x, logic [15:0] y, logic [15:0] h,
                             bit typed, cmd_word_t typed_w);
        // occasional gap with junk on the payload
        if (!steady && $urandom_range(99) < 5)
        begin
            pose_ch.valid              <= 1'b0;
            pose_ch.object_x_mm        <= 16'($urandom);
            pose_ch.object_y_mm        <= 16'($urandom);
            pose_ch.heading_error_mrad <= 16'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pose_ch.valid              <= 1'b1;
        pose_ch.object_x_mm        <= x;
        pose_ch.object_y_mm        <= y;
        pose_ch.heading_error_mrad <= h;
        do @(posedge clk); while (!pose_ch.ready);
        expected_cmds.push_back(typed ? typed_w : plan_approach(x, y, h));
    endtask

    // no pose in flight and every command back
    task automatic wait_idle();
        pose_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // backpressure at random with a ten percent chance, none during a steady stretch
    always @(posedge clk)
    begin
        cmd_ch.ready <= steady || ($urandom_range(99) >= 10);
    end

    // every accepted command against the oldest prediction, field by field
    always @(posedge clk)
    begin : cmd_monitor
        cmd_word_t got;
        cmd_word_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            got[0] = avp_pkg::ERR_W'(cmd_ch.approach_state);
            got[1] = cmd_ch.forward_error_mm;
            got[2] = cmd_ch.lateral_error_mm;
            got[3] = cmd_ch.forward_speed;
            got[4] = cmd_ch.lateral_speed;
            got[5] = cmd_ch.yaw_rate;
            if (expected_cmds.size() == 0)
            begin
                report_mismatch("command with no pose pending", 64'(got[0]), 64'h0);
            end
            else
            begin
                want = expected_cmds.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        report_mismatch(cmd_labels[i], 64'(got[i]), 64'(want[i]));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int        x, y, h, sx, sy, tx, ty, tol_x, tol_y, tol_h, n_items;
        bit        cur_bad;
        cmd_word_t typed_w;

        // every input known from time zero
        rst_n                      = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        pose_ch.valid              = 1'b0;
        pose_ch.object_x_mm        = '0;
        pose_ch.object_y_mm        = '0;
        pose_ch.heading_error_mrad = '0;
        cmd_ch.ready               = 1'b0;

        // shadow settings start at the reset defaults
        regs[avp_pkg::REG_TARGET_X]    = 64'(avp_pkg::RST_TARGET_X);
        regs[avp_pkg::REG_TARGET_Y]    = 64'(avp_pkg::RST_TARGET_Y);
        regs[avp_pkg::REG_MIN_FORWARD] = 64'(avp_pkg::RST_MIN_FORWARD);
        regs[avp_pkg::REG_TOLERANCES]  = 64'(avp_pkg::RST_TOLERANCES);
        regs[avp_pkg::REG_FLOORS]      = 64'(avp_pkg::RST_FLOORS);
        regs[avp_pkg::REG_CEILINGS]    = 64'(avp_pkg::RST_CEILINGS);
        regs[avp_pkg::REG_SPEED_GAIN]  = 64'(avp_pkg::RST_SPEED_GAIN);
        regs[avp_pkg::REG_YAW_GAIN]    = 64'(avp_pkg::RST_YAW_GAIN);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values visible on the port
        for (int i = 0; i < 8; i++)
        begin
            check_register(avp_pkg::REG_IDX_W'(i));
        end

        // directed walk; the speed gain goes to zero for the unusable rows
        cur_bad = 1'b0;
        for (int i = 0; i < PROBE_N; i++)
        begin
            if (probes[i].bad != cur_bad)
            begin
                wait_idle();
                cur_bad = probes[i].bad;
                set_register(avp_pkg::REG_SPEED_GAIN,
                             cur_bad ? 64'h0 : 64'(avp_pkg::RST_SPEED_GAIN));
            end
            typed_w[0] = avp_pkg::ERR_W'(probes[i].st);
            typed_w[1] = avp_pkg::ERR_W'(probes[i].ex);
            typed_w[2] = avp_pkg::ERR_W'(probes[i].ey);
            typed_w[3] = avp_pkg::ERR_W'(probes[i].vx);
            typed_w[4] = avp_pkg::ERR_W'(probes[i].vy);
            typed_w[5] = avp_pkg::ERR_W'(probes[i].yaw);
            send_pose(16'(probes[i].x), 16'(probes[i].y), 16'(probes[i].h),
                      probes[i].typed, typed_w);
        end

        // random phases: all zero, all ones, extreme usable, then random settings
        for (int p = 0; p < 13; p++)
        begin
            wait_idle();
            load_settings((p < 3) ? p : 3);
            steady = (p == 5);
            n_items = (p < 2) ? 60 : 150;

            tx    = int'(regs[avp_pkg::REG_TARGET_X][14:0]);
            ty    = int'($signed(regs[avp_pkg::REG_TARGET_Y][15:0]));
            tol_x = int'(regs[avp_pkg::REG_TOLERANCES][15:0]);
            tol_y = int'(regs[avp_pkg::REG_TOLERANCES][31:16]);
            tol_h = int'(regs[avp_pkg::REG_TOLERANCES][47:32]);

            for (int n = 0; n < n_items; n++)
            begin
                if ($urandom_range(99) < 25)
                begin
                    // anywhere in the field ranges
                    x = int'($signed(16'($urandom)));
                    y = int'($signed(16'($urandom)));
                    h = int'($signed(16'($urandom)));
                end
                else
                begin
                    // around the target: deadband edges, floors, overshoot
                    sx = $urandom_range(1) ? 3 * tol_x + 8 : 2500;
                    sy = $urandom_range(1) ? 3 * tol_y + 8 : 2500;
                    x  = tx + int'($urandom_range(2 * sx)) - sx;
                    y  = ty + int'($urandom_range(2 * sy)) - sy;
                    if ($urandom_range(1))
                    begin
                        h = int'($urandom_range(4 * tol_h + 8)) - 2 * tol_h - 4;
                    end
                    else
                    begin
                        h = int'($signed(16'($urandom)));
                    end
                end
                send_pose(16'(x), 16'(y), 16'(h), 1'b0, '0);
            end
        end
        steady = 1'b0;

        // drain, then wait for anything unexpected to show up
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS approach_velocity_planner_top");
        end
        else
        begin
            $display("FAIL approach_velocity_planner_top");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("FAIL approach_velocity_planner_top");
        $finish;
    end

endmodule
